// ===== design/pcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcc_pkg: shared definitions for the prime and coprime checker
// Operand width, remainder step counter width, square width and command codes.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int VALUE_BITS = 31;
    // Remainder unit counts down from VALUE_BITS to one
    localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
    // Running square of the trial divisor overshoots the candidate by < 2*sqrt+1
    localparam int SQ_BITS    = VALUE_BITS + 1;

    typedef logic [VALUE_BITS-1:0] t_value;

    typedef enum logic {
        CMD_PRIME   = 1'b0,
        CMD_COPRIME = 1'b1
    } t_cmd;

endpackage

// ===== design/pcc_rem_unit.sv =====
// ----------------------------------------------------------------------------
// pcc_rem_unit: bit-serial remainder
// Restoring division, one dividend bit per cycle; gives dividend % divisor
// with a done strobe once the last dividend bit is in. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module pcc_rem_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  pcc_pkg::t_value i_dividend,
    input  pcc_pkg::t_value i_divisor,
    output logic           o_done,
    output pcc_pkg::t_value o_rem
);
    import pcc_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                r_state;
    logic                  r_done;
    logic [CNT_BITS-1:0]   r_cnt;
    t_value                r_dvd;
    t_value                r_dvs;
    t_value                r_rem;

    logic [VALUE_BITS:0]   w_trial;
    logic [VALUE_BITS:0]   w_diff;
    t_value                n_rem;

    // Shift in the next dividend bit, subtract divisor where it fits
    always_comb begin
        w_trial = {r_rem, r_dvd[VALUE_BITS-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        if (w_diff[VALUE_BITS]) begin
            n_rem = w_trial[VALUE_BITS-1:0];
        end else begin
            n_rem = w_diff[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_dvd   <= i_dividend;
                        r_dvs   <= i_divisor;
                        r_rem   <= '0;
                        r_cnt   <= CNT_BITS'(VALUE_BITS);
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_rem <= n_rem;
                    r_dvd <= {r_dvd[VALUE_BITS-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_BITS'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== design/prime_and_coprime_checker_unit.sv =====
// ----------------------------------------------------------------------------
// prime_and_coprime_checker_unit: trial-division prime test and Euclid test
// Work: each trial divisor or Euclid step runs one remainder in pcc_rem_unit;
//   at 31 bits a prime test tries up to about 46340 divisors.
// Throughput: one word at a time; busy stays high until the verdict strobe,
//   and the next word may be taken in the strobe cycle.
// Reset: synchronous, active low; returns to idle and drops any work.
// The verdict is shown for one cycle only; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module prime_and_coprime_checker_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            i_cmd,
    input  pcc_pkg::t_value i_first_value,
    input  pcc_pkg::t_value i_second_value,
    output logic            o_result_valid,
    output logic            o_verdict
);
    import pcc_pkg::*;

    // Prime: r_a holds the candidate, r_b the trial divisor, r_sq its square.
    // Coprime: r_a and r_b hold the Euclid pair.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PCHK,
        S_PWAIT,
        S_GCHK,
        S_GWAIT
    } t_state;

    t_state               r_state;
    logic                 r_valid;
    logic                 r_verdict;
    logic                 r_rem_start;
    t_value               r_a;
    t_value               r_b;
    logic [SQ_BITS-1:0]   r_sq;

    logic                 w_rem_done;
    t_value               w_rem;

    pcc_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_rem_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= 1'b0;
            r_verdict   <= 1'b0;
            r_rem_start <= 1'b0;
        end else begin
            // Strobe and remainder start are single-cycle pulses
            r_valid     <= 1'b0;
            r_rem_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_a  <= i_first_value;
                        if (t_cmd'(i_cmd) == CMD_COPRIME) begin
                            r_b     <= i_second_value;
                            r_state <= S_GCHK;
                        end else if (i_first_value < VALUE_BITS'(2)) begin
                            // Zero and one are not prime: answer at once
                            r_valid   <= 1'b1;
                            r_verdict <= 1'b0;
                        end else begin
                            r_b     <= VALUE_BITS'(2);
                            r_sq    <= SQ_BITS'(4);
                            r_state <= S_PCHK;
                        end
                    end
                end
                S_PCHK: begin
                    if (r_sq > {1'b0, r_a}) begin
                        // No divisor up to the square root: prime
                        r_valid   <= 1'b1;
                        r_verdict <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_rem_start <= 1'b1;
                        r_state     <= S_PWAIT;
                    end
                end
                S_PWAIT: begin
                    if (w_rem_done) begin
                        if (w_rem == '0) begin
                            r_valid   <= 1'b1;
                            r_verdict <= 1'b0;
                            r_state   <= S_IDLE;
                        end else begin
                            // Advance divisor; (d+1)^2 = d^2 + 2d + 1
                            r_b     <= r_b + 1'b1;
                            r_sq    <= r_sq + {r_b, 1'b1};
                            r_state <= S_PCHK;
                        end
                    end
                end
                S_GCHK: begin
                    if (r_b == '0) begin
                        // gcd sits in r_a: coprime only when it is one
                        r_valid   <= 1'b1;
                        r_verdict <= (r_a == VALUE_BITS'(1));
                        r_state   <= S_IDLE;
                    end else begin
                        r_rem_start <= 1'b1;
                        r_state     <= S_GWAIT;
                    end
                end
                S_GWAIT: begin
                    if (w_rem_done) begin
                        r_a     <= r_b;
                        r_b     <= w_rem;
                        r_state <= S_GCHK;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_valid;
    assign o_verdict      = r_verdict;

endmodule

// ===== design/pcc_checker.sv =====
// ----------------------------------------------------------------------------
// pcc_checker: port-level checks for the prime and coprime checker
// Watches the command handshake and the verdict strobe.
// ----------------------------------------------------------------------------
module pcc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_result_valid
);

    // An accepted word of a nontrivial test raises busy, else answers at once
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_result_valid)
        else $error("accepted word neither raised busy nor answered");

    // The verdict strobe comes only once the work is finished
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("verdict shown while still busy");

    // Busy drops only together with a verdict
    a_fall_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("busy dropped without a verdict");

    // One verdict per word: no strobe without a preceding accept or busy
    a_valid_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(busy) && !$past(start) |-> !o_result_valid)
        else $error("verdict strobe without a word in flight");

endmodule

bind prime_and_coprime_checker_unit pcc_checker u_pcc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid)
);
